@@ sv/dssl_pkg.sv @@
package dssl_pkg;

    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 15;
    localparam int DUTY_W  = 11;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_STEP      = 3'd0,
        REG_DEADBAND  = 3'd1,
        REG_MAX_FIRST = 3'd2,
        REG_MAX_SECND = 3'd3,
        REG_MIN_PULSE = 3'd4,
        REG_MAX_PULSE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] step;
        logic [ANGLE_W-1:0] deadband;
        logic [ANGLE_W-1:0] ang_limit;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
    } t_lane_cfg;

    typedef struct packed {
        logic              write;
        logic [DUTY_W-1:0] duty;
        logic              stop;
    } t_lane_res;

endpackage

@@ sv/dssl_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dssl_div import dssl_pkg::*; #(
    parameter int NW = 27,
    parameter int DW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_shift = {r_rem, r_num[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

endmodule

@@ sv/dssl_lane.sv @@
// One servo axis: slew step, write/stop decision and duty computation.
module dssl_lane import dssl_pkg::*; #(
    parameter int DUTY_FULL_SCALE = 1024,
    parameter int PERIOD_US       = 20000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_cfg          i_cfg,
    input  logic               i_accept,
    input  logic [ANGLE_W-1:0] i_target,
    input  logic               i_go,
    input  logic               i_any_moved,
    output logic               o_moved,
    output logic               o_busy,
    output t_lane_res          o_res,
    output logic [ANGLE_W-1:0] o_angle
);
    localparam int PROD_W = ANGLE_W + PULSE_W;
    // duty = pulse*DUTY_FULL_SCALE/PERIOD_US via reciprocal multiply; the
    // shift RS = SN_W + SH_W keeps the floor exact for every SN_W-bit numerator
    localparam int SN_W = (PULSE_W + 1) + $clog2(DUTY_FULL_SCALE + 1);
    localparam int SH_W = $clog2(PERIOD_US + 1);
    localparam int RS   = SN_W + SH_W;
    localparam int RC_W = SN_W + 2;
    localparam int RP_W = SN_W + RC_W;
    localparam int QW   = RP_W - RS;
    localparam logic [RC_W-1:0] RECIP =
        RC_W'(((64'd1 << RS) + 64'(PERIOD_US) - 64'd1) / 64'(PERIOD_US));

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV1S,
        L_DIV1,
        L_MUL,
        L_SAT
    } t_lstate;

    t_lstate            r_state;
    logic [ANGLE_W-1:0] r_pos;
    logic [ANGLE_W-1:0] r_sent;
    logic               r_running;
    logic               r_moved;
    logic [PROD_W-1:0]  r_prod;
    logic               r_zero;
    logic [PULSE_W:0]   r_pulse;
    logic [RP_W-1:0]    r_recip_prod;
    t_lane_res          r_res;

    logic [ANGLE_W-1:0] w_tgt;
    logic [ANGLE_W-1:0] w_gap;
    logic [ANGLE_W:0]   w_up;
    logic [ANGLE_W-1:0] w_dn;
    logic [ANGLE_W-1:0] n_pos;
    logic [ANGLE_W-1:0] w_angle;
    logic [PULSE_W-1:0] w_span;
    logic               w_write;
    logic               w_stop;
    logic [SN_W-1:0]    w_scaled_num;
    logic [QW-1:0]      w_duty_q;

    logic               w_div_start;
    logic               w_div_busy;
    logic [PROD_W-1:0]  w_div_quot;

    // slew toward the clamped target
    always_comb begin
        w_tgt = (i_target > i_cfg.ang_limit) ? i_cfg.ang_limit : i_target;
        w_gap = (r_pos > w_tgt) ? r_pos - w_tgt : w_tgt - r_pos;
        w_up  = {1'b0, r_pos} + {1'b0, i_cfg.step};
        w_dn  = (r_pos >= i_cfg.step) ? r_pos - i_cfg.step : '0;
        n_pos = r_pos;
        if (w_gap >= i_cfg.deadband) begin
            if (r_pos < w_tgt) begin
                n_pos = (w_up > {1'b0, w_tgt}) ? w_tgt : w_up[ANGLE_W-1:0];
            end else if (r_pos > w_tgt) begin
                n_pos = (w_dn < w_tgt) ? w_tgt : w_dn;
            end
        end
    end

    assign w_angle = (r_pos > i_cfg.ang_limit) ? i_cfg.ang_limit : r_pos;
    assign w_span  = (i_cfg.max_pulse >= i_cfg.min_pulse) ?
                     i_cfg.max_pulse - i_cfg.min_pulse : '0;
    assign w_write = i_any_moved && (r_pos != r_sent);
    assign w_stop  = !i_any_moved && r_running;

    assign w_div_start  = (r_state == L_DIV1S);
    assign w_scaled_num = SN_W'(r_pulse) * SN_W'(DUTY_FULL_SCALE);
    assign w_duty_q     = r_recip_prod[RP_W-1:RS];

    // angle*span / angle limit
    dssl_div #(
        .NW (PROD_W),
        .DW (ANGLE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (i_cfg.ang_limit),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= L_IDLE;
            r_pos     <= '0;
            r_sent    <= '0;
            r_running <= 1'b0;
            r_moved   <= 1'b0;
        end else begin
            if (i_accept) begin
                r_pos   <= n_pos;
                r_moved <= (n_pos != r_pos);
            end
            unique case (r_state)
                L_IDLE: begin
                    if (i_go) begin
                        r_res.write <= w_write;
                        r_res.stop  <= w_stop;
                        r_res.duty  <= '0;
                        r_prod      <= PROD_W'(w_angle) * PROD_W'(w_span);
                        r_zero      <= (i_cfg.ang_limit == '0);
                        if (w_write) begin
                            r_sent    <= r_pos;
                            r_running <= 1'b1;
                            r_state   <= L_DIV1S;
                        end else if (w_stop) begin
                            r_running <= 1'b0;
                        end
                    end
                end
                L_DIV1S: begin
                    r_state <= L_DIV1;
                end
                L_DIV1: begin
                    if (!w_div_busy) begin
                        r_pulse <= {1'b0, i_cfg.min_pulse} +
                                   (r_zero ? '0 : {1'b0, w_div_quot[PULSE_W-1:0]});
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_recip_prod <= RP_W'(w_scaled_num) * RP_W'(RECIP);
                    r_state      <= L_SAT;
                end
                L_SAT: begin
                    r_res.duty <= ((DUTY_W + QW)'(w_duty_q) > (DUTY_W + QW)'(DUTY_MAX)) ?
                                  DUTY_MAX : w_duty_q[DUTY_W-1:0];
                    r_state    <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_moved = r_moved;
    assign o_busy  = (r_state != L_IDLE);
    assign o_res   = r_res;
    assign o_angle = r_pos;

endmodule

@@ sv/dual_servo_slew_limiter_unit.sv @@
// A tick that writes a duty has its result in the output register after a
// serial divide by the angle limit, a reciprocal multiply by the PWM period
// and a saturate; stop/hold ticks skip these steps.
// Only one tick is in flight; the next input transfer can come in the cycle
// after the result loads; a full output register holds it off.
// Synchronous active-low reset clears positions, sent angles, active flags, loads defaults.
module dual_servo_slew_limiter_unit import dssl_pkg::*; #(
    parameter int DUTY_FULL_SCALE = 1024,
    parameter int PERIOD_US       = 20000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // tick input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // [7:0] target_first, [15:8] target_second
    // result output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] write_first, [11:1] duty_first, [12] stop_first, [13] write_second,
    // [24:14] duty_second, [25] stop_second, [33:26] angle_first,
    // [41:34] angle_second, [47:42] zero
    output logic [47:0]       m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_WORK
    } t_state;

    t_state             r_state;
    logic [ANGLE_W-1:0] r_step;
    logic [ANGLE_W-1:0] r_deadband;
    logic [ANGLE_W-1:0] r_max_first;
    logic [ANGLE_W-1:0] r_max_second;
    logic [PULSE_W-1:0] r_min_pulse;
    logic [PULSE_W-1:0] r_max_pulse;
    logic               r_out_valid;
    logic [47:0]        r_out_data;

    t_lane_cfg          w_cfg_first;
    t_lane_cfg          w_cfg_second;
    t_lane_res          w_res_first;
    t_lane_res          w_res_second;
    logic [ANGLE_W-1:0] w_angle_first;
    logic [ANGLE_W-1:0] w_angle_second;
    logic               w_moved_first;
    logic               w_moved_second;
    logic               w_busy_first;
    logic               w_busy_second;
    logic               w_accept;
    logic               w_go;
    logic               w_any_moved;
    logic               w_load;
    logic               w_cfg_wr;
    t_reg_idx           w_idx;

    // ---------------- configuration registers ----------------
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ANGLE_W'(2);
            r_deadband   <= ANGLE_W'(2);
            r_max_first  <= ANGLE_W'(180);
            r_max_second <= ANGLE_W'(90);
            r_min_pulse  <= PULSE_W'(600);
            r_max_pulse  <= PULSE_W'(2400);
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_STEP:      r_step       <= pwdata[ANGLE_W-1:0];
                REG_DEADBAND:  r_deadband   <= pwdata[ANGLE_W-1:0];
                REG_MAX_FIRST: r_max_first  <= pwdata[ANGLE_W-1:0];
                REG_MAX_SECND: r_max_second <= pwdata[ANGLE_W-1:0];
                REG_MIN_PULSE: r_min_pulse  <= pwdata[PULSE_W-1:0];
                REG_MAX_PULSE: r_max_pulse  <= pwdata[PULSE_W-1:0];
                default: ;  // unmapped offsets ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP:      prdata = DATA_W'(r_step);
            REG_DEADBAND:  prdata = DATA_W'(r_deadband);
            REG_MAX_FIRST: prdata = DATA_W'(r_max_first);
            REG_MAX_SECND: prdata = DATA_W'(r_max_second);
            REG_MIN_PULSE: prdata = DATA_W'(r_min_pulse);
            REG_MAX_PULSE: prdata = DATA_W'(r_max_pulse);
            default:       prdata = '0;
        endcase
    end

    assign w_cfg_first  = '{step: r_step, deadband: r_deadband, ang_limit: r_max_first,
                            min_pulse: r_min_pulse, max_pulse: r_max_pulse};
    assign w_cfg_second = '{step: r_step, deadband: r_deadband, ang_limit: r_max_second,
                            min_pulse: r_min_pulse, max_pulse: r_max_pulse};

    // ---------------- axis lanes ----------------
    // Both lanes step on the input transfer; in the next cycle the merge
    // decides write, stop or hold from the pair of move flags, and each lane
    // runs its own divider for the duty.
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_go          = (r_state == S_MERGE);
    assign w_any_moved   = w_moved_first || w_moved_second;

    dssl_lane #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
        .PERIOD_US       (PERIOD_US)
    ) u_lane_first (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg_first),
        .i_accept    (w_accept),
        .i_target    (s_axis_tdata[7:0]),
        .i_go        (w_go),
        .i_any_moved (w_any_moved),
        .o_moved     (w_moved_first),
        .o_busy      (w_busy_first),
        .o_res       (w_res_first),
        .o_angle     (w_angle_first)
    );

    dssl_lane #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
        .PERIOD_US       (PERIOD_US)
    ) u_lane_second (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg_second),
        .i_accept    (w_accept),
        .i_target    (s_axis_tdata[15:8]),
        .i_go        (w_go),
        .i_any_moved (w_any_moved),
        .o_moved     (w_moved_second),
        .o_busy      (w_busy_second),
        .o_res       (w_res_second),
        .o_angle     (w_angle_second)
    );

    // ---------------- sequencing and output register ----------------
    // Result loads once both lanes are done and the output register is
    // free (or being drained this cycle).
    assign w_load = (r_state == S_WORK) && !w_busy_first && !w_busy_second &&
                    (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (w_accept) r_state <= S_MERGE;
                S_MERGE: r_state <= S_WORK;
                S_WORK:  if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {6'd0, w_angle_second, w_angle_first,
                           w_res_second.stop, w_res_second.duty, w_res_second.write,
                           w_res_first.stop, w_res_first.duty, w_res_first.write};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // a tick either writes duties or stops axes, never both
    a_write_excl_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[0] || r_out_data[13]) |->
            !(r_out_data[12] || r_out_data[25]))
        else $error("write and stop in the same result");

    // duty_first reads zero unless the first axis is written
    a_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[0] |-> (r_out_data[11:1] == '0))
        else $error("duty_first nonzero without write");

    // one tick in flight: no new transfer right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input taken while a tick is in flight");

    // lanes are idle whenever a new tick can be taken
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_busy_first && !w_busy_second)
        else $error("lane busy while accepting input");

endmodule
